// ===== rtl/core/vdi_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vdi_pkg
// Shared types and constants of the vertex dedup indexer.
// ----------------------------------------------------------------------------
package vdi_pkg;

  localparam int MAX_UNIQUE_DEF   = 4096;
  localparam int MAX_VERTICES_DEF = 8192;
  localparam int KEY_WORDS_DEF    = 4;

  localparam int WORD_W      = 64;
  localparam int INPUT_WORDS = 4;
  localparam int KWIU_W      = 3;
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;

  localparam logic [KWIU_W-1:0] KWIU_RESET = 3'd4;
  localparam logic              REG_KWIU   = 1'b0;

  localparam logic [1:0] FUNC_SUBMIT = 2'd0;
  localparam logic [1:0] FUNC_XLATE  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  localparam logic [1:0] OP_SUBMIT = 2'd0;
  localparam logic [1:0] OP_XLATE  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0]                         op;
    logic [INPUT_WORDS-1:0][WORD_W-1:0] words;
  } job_t;

endpackage
`default_nettype wire

// ===== rtl/core/vertex_dedup_indexer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_dedup_indexer
// Builds a deduplicated index buffer from vertex keys.
//
// Input queue: push/full with func, key_word_0..3 and old_vertex. A submit
// compares the first key_words_in_use words (clamped to 1..KEY_WORDS)
// against the stored unique keys in index order, one stored key per cycle,
// until the first hit. A hit returns the earlier index; a miss stores the key
// and returns the next index with is_new and the pick vertex; a full vertex or
// unique table gives status FULL. A translate returns the mapped index of an
// already submitted vertex, else status RANGE; a clear empties both tables.
// Result queue: empty/pop; the head result is on the ports while empty is low.
// The engine holds one item at a time and takes the next one once the result
// of the last is queued and the result queue has room; two items and two
// results can be queued.
// Reset clears counters and queues; key_words_in_use returns to 4. Tables
// need no clearing. A stalled receiver fills the result queue, then the
// engine waits and the input queue fills.
// Config: APB byte address 0 holds key_words_in_use.
// ----------------------------------------------------------------------------
module vertex_dedup_indexer import vdi_pkg::*; #(
  parameter int MAX_UNIQUE   = MAX_UNIQUE_DEF,
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int KEY_WORDS    = KEY_WORDS_DEF,
  parameter int UAW          = $clog2(MAX_UNIQUE),
  parameter int VAW          = $clog2(MAX_VERTICES)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [1:0]        func,
  input  wire logic [WORD_W-1:0] key_word_0,
  input  wire logic [WORD_W-1:0] key_word_1,
  input  wire logic [WORD_W-1:0] key_word_2,
  input  wire logic [WORD_W-1:0] key_word_3,
  input  wire logic [VAW-1:0]    old_vertex,
  output logic                   empty,
  input  wire logic              pop,
  output logic [UAW-1:0]         new_index,
  output logic                   is_new,
  output logic [VAW-1:0]         pick_vertex,
  output logic [1:0]             status
);

  logic [KWIU_W-1:0] kwiu;
  logic              job_valid;
  logic              job_take;
  job_t              job;
  logic [VAW-1:0]    job_old;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_KWIU) ? APB_DW'(kwiu) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      kwiu <= KWIU_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_KWIU)) begin
      kwiu <= pwdata[KWIU_W-1:0];
    end
  end

  vdi_front #(
    .VAW(VAW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .func       (func),
    .key_word_0 (key_word_0),
    .key_word_1 (key_word_1),
    .key_word_2 (key_word_2),
    .key_word_3 (key_word_3),
    .old_vertex (old_vertex),
    .job_valid  (job_valid),
    .job_take   (job_take),
    .job        (job),
    .job_old    (job_old)
  );

  vdi_back #(
    .MAX_UNIQUE   (MAX_UNIQUE),
    .MAX_VERTICES (MAX_VERTICES),
    .KEY_WORDS    (KEY_WORDS),
    .UAW          (UAW),
    .VAW          (VAW)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .kwiu        (kwiu),
    .job_valid   (job_valid),
    .job_take    (job_take),
    .job         (job),
    .job_old     (job_old),
    .empty       (empty),
    .pop         (pop),
    .new_index   (new_index),
    .is_new      (is_new),
    .pick_vertex (pick_vertex),
    .status      (status)
  );

endmodule
`default_nettype wire

// ===== rtl/core/vdi_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vdi_front
// Input queue: takes items, decodes the function code, holds two jobs.
// ----------------------------------------------------------------------------
module vdi_front import vdi_pkg::*; #(
  parameter int VAW = 13
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [1:0]        func,
  input  wire logic [WORD_W-1:0] key_word_0,
  input  wire logic [WORD_W-1:0] key_word_1,
  input  wire logic [WORD_W-1:0] key_word_2,
  input  wire logic [WORD_W-1:0] key_word_3,
  input  wire logic [VAW-1:0]    old_vertex,
  output logic                   job_valid,
  input  wire logic              job_take,
  output job_t                   job,
  output logic [VAW-1:0]         job_old
);

  job_t           q_job [2];
  logic [VAW-1:0] q_old [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     cnt;
  logic           do_push;
  logic           do_pop;
  job_t           in_job;

  always_comb begin
    unique case (func)
      FUNC_SUBMIT: in_job.op = OP_SUBMIT;
      FUNC_XLATE:  in_job.op = OP_XLATE;
      FUNC_CLEAR:  in_job.op = OP_CLEAR;
      default:     in_job.op = OP_NOP;
    endcase
    in_job.words = {key_word_3, key_word_2, key_word_1, key_word_0};
  end

  assign full      = (cnt == 2'd2);
  assign job_valid = (cnt != 2'd0);
  assign do_push   = push && !full;
  assign do_pop    = job_take && job_valid;
  assign job       = q_job[rd_ptr];
  assign job_old   = q_old[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_job[wr_ptr] <= in_job;
      q_old[wr_ptr] <= old_vertex;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      cnt <= cnt + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/vdi_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vdi_back
// Execution engine: key table scan, index map, counters and result queue.
// ----------------------------------------------------------------------------
module vdi_back import vdi_pkg::*; #(
  parameter int MAX_UNIQUE   = MAX_UNIQUE_DEF,
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int KEY_WORDS    = KEY_WORDS_DEF,
  parameter int UAW          = $clog2(MAX_UNIQUE),
  parameter int VAW          = $clog2(MAX_VERTICES)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [KWIU_W-1:0] kwiu,
  input  wire logic              job_valid,
  output logic                   job_take,
  input  wire job_t              job,
  input  wire logic [VAW-1:0]    job_old,
  output logic                   empty,
  input  wire logic              pop,
  output logic [UAW-1:0]         new_index,
  output logic                   is_new,
  output logic [VAW-1:0]         pick_vertex,
  output logic [1:0]             status
);

  localparam int UCW = $clog2(MAX_UNIQUE + 1);
  localparam int VCW = $clog2(MAX_VERTICES + 1);
  localparam int KW  = WORD_W * KEY_WORDS;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_NEW   = 2'd2;
  localparam logic [1:0] S_XLATE = 2'd3;

  logic [1:0]     state;
  logic [VCW-1:0] vcnt;
  logic [UCW-1:0] ucnt;
  logic [UCW-1:0] issue;
  logic           cmp_valid;
  logic [UAW-1:0] cmp_addr;
  logic [KW-1:0]  cur_row;
  logic           xl_ok;

  logic [KW-1:0]  key_mem [MAX_UNIQUE];
  logic [KW-1:0]  rd_row;
  logic [UAW-1:0] map_mem [MAX_VERTICES];
  logic [UAW-1:0] map_rd;

  logic [KW-1:0]  row_in;
  logic [3:0]     n_cmp;
  logic           match;
  logic           last;
  logic           vfull;
  logic           ufull;
  logic           key_wr;
  logic           map_wr;
  logic [UAW-1:0] map_wr_data;

  logic           res_push;
  logic [UAW-1:0] res_idx;
  logic           res_new;
  logic [VAW-1:0] res_pick;
  logic [1:0]     res_st;

  logic [UAW-1:0] oq_idx  [2];
  logic           oq_new  [2];
  logic [VAW-1:0] oq_pick [2];
  logic [1:0]     oq_st   [2];
  logic           oq_wr;
  logic           oq_rd;
  logic [1:0]     oq_cnt;
  logic           oq_pop;

  always_comb begin
    for (int w = 0; w < KEY_WORDS; w++) begin
      row_in[w*WORD_W +: WORD_W] = (w < INPUT_WORDS) ? job.words[w] : '0;
    end
  end

  always_comb begin
    if (kwiu == '0) n_cmp = 4'd1;
    else if (4'(kwiu) > 4'(KEY_WORDS)) n_cmp = 4'(KEY_WORDS);
    else n_cmp = 4'(kwiu);
    match = 1'b1;
    for (int w = 0; w < KEY_WORDS; w++) begin
      if ((4'(w) < n_cmp) && (rd_row[w*WORD_W +: WORD_W] != cur_row[w*WORD_W +: WORD_W]))
        match = 1'b0;
    end
  end

  assign vfull = (vcnt >= VCW'(MAX_VERTICES));
  assign ufull = (ucnt >= UCW'(MAX_UNIQUE));
  assign last  = ((UCW'(cmp_addr) + UCW'(1)) == ucnt);

  always_comb begin
    job_take    = 1'b0;
    res_push    = 1'b0;
    res_idx     = '0;
    res_new     = 1'b0;
    res_pick    = '0;
    res_st      = ST_OK;
    key_wr      = 1'b0;
    map_wr      = 1'b0;
    map_wr_data = '0;
    unique case (state)
      S_IDLE: begin
        if (job_valid && (oq_cnt != 2'd2)) begin
          job_take = 1'b1;
          case (job.op)
            OP_SUBMIT: begin
              if (vfull) begin
                res_push = 1'b1;
                res_st   = ST_FULL;
              end
            end
            OP_XLATE: ;
            default: res_push = 1'b1;
          endcase
        end
      end
      S_SCAN: begin
        if (cmp_valid && match) begin
          res_push    = 1'b1;
          res_idx     = cmp_addr;
          map_wr      = 1'b1;
          map_wr_data = cmp_addr;
        end
      end
      S_NEW: begin
        res_push = 1'b1;
        if (ufull) begin
          res_st = ST_FULL;
        end else begin
          key_wr      = 1'b1;
          map_wr      = 1'b1;
          map_wr_data = ucnt[UAW-1:0];
          res_idx     = ucnt[UAW-1:0];
          res_new     = 1'b1;
          res_pick    = vcnt[VAW-1:0];
        end
      end
      S_XLATE: begin
        res_push = 1'b1;
        if (xl_ok) res_idx = map_rd;
        else res_st = ST_RANGE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      vcnt      <= '0;
      ucnt      <= '0;
      cmp_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (job_take) begin
            case (job.op)
              OP_SUBMIT: begin
                if (!vfull) begin
                  cur_row <= row_in;
                  issue   <= '0;
                  state   <= (ucnt == '0) ? S_NEW : S_SCAN;
                end
              end
              OP_XLATE: begin
                xl_ok <= (VCW'(job_old) < vcnt);
                state <= S_XLATE;
              end
              OP_CLEAR: begin
                vcnt <= '0;
                ucnt <= '0;
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (cmp_valid && match) begin
            vcnt      <= vcnt + VCW'(1);
            cmp_valid <= 1'b0;
            state     <= S_IDLE;
          end else if (cmp_valid && last) begin
            cmp_valid <= 1'b0;
            state     <= S_NEW;
          end else if (issue < ucnt) begin
            cmp_valid <= 1'b1;
            cmp_addr  <= issue[UAW-1:0];
            issue     <= issue + UCW'(1);
          end else begin
            cmp_valid <= 1'b0;
          end
        end
        S_NEW: begin
          if (!ufull) begin
            ucnt <= ucnt + UCW'(1);
            vcnt <= vcnt + VCW'(1);
          end
          state <= S_IDLE;
        end
        S_XLATE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (key_wr) key_mem[ucnt[UAW-1:0]] <= cur_row;
    rd_row <= key_mem[issue[UAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (map_wr) map_mem[vcnt[VAW-1:0]] <= map_wr_data;
    map_rd <= map_mem[job_old];
  end

  assign empty       = (oq_cnt == 2'd0);
  assign oq_pop      = pop && !empty;
  assign new_index   = oq_idx[oq_rd];
  assign is_new      = oq_new[oq_rd];
  assign pick_vertex = oq_pick[oq_rd];
  assign status      = oq_st[oq_rd];

  always_ff @(posedge clk) begin
    if (res_push) begin
      oq_idx[oq_wr]  <= res_idx;
      oq_new[oq_wr]  <= res_new;
      oq_pick[oq_wr] <= res_pick;
      oq_st[oq_wr]   <= res_st;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr  <= 1'b0;
      oq_rd  <= 1'b0;
      oq_cnt <= 2'd0;
    end else begin
      if (res_push) oq_wr <= ~oq_wr;
      if (oq_pop)   oq_rd <= ~oq_rd;
      oq_cnt <= oq_cnt + 2'(res_push) - 2'(oq_pop);
    end
  end

`ifndef SYNTHESIS
  a_oq_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(res_push && (oq_cnt == 2'd2) && !oq_pop))
    else $error("result queue overflow");
  a_unique_le_vertices: assert property (@(posedge clk) disable iff (rst)
    (VCW + 1)'(ucnt) <= (VCW + 1)'(vcnt))
    else $error("unique count above vertex count");
  a_ucnt_bound: assert property (@(posedge clk) disable iff (rst)
    ucnt <= UCW'(MAX_UNIQUE))
    else $error("unique count out of range");
  a_cmp_only_scan: assert property (@(posedge clk) disable iff (rst)
    cmp_valid |-> (state == S_SCAN))
    else $error("compare valid outside scan");
`endif

endmodule
`default_nettype wire

// ===== dv/vertex_dedup_indexer_checker.sv =====
// ----------------------------------------------------------------------------
// vertex_dedup_indexer_checker
// Watches the config port, the item queue and the result queue of the vertex
// dedup indexer. It keeps its own key table and index map, works out the
// result of every accepted item and compares each popped result, field by
// field, with the oldest outstanding one.
// ----------------------------------------------------------------------------
module vertex_dedup_indexer_checker import vdi_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  input  logic              push,
  input  logic              full,
  input  logic [1:0]        func,
  input  logic [WORD_W-1:0] key_word_0,
  input  logic [WORD_W-1:0] key_word_1,
  input  logic [WORD_W-1:0] key_word_2,
  input  logic [WORD_W-1:0] key_word_3,
  input  logic [12:0]       old_vertex,
  input  logic              empty,
  input  logic              pop,
  input  logic [11:0]       new_index,
  input  logic              is_new,
  input  logic [12:0]       pick_vertex,
  input  logic [1:0]        status,
  output int                fail_count,
  output int                outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [11:0] idx;
    logic        fresh;
    logic [12:0] pick;
    logic [1:0]  st;
  } dedup_result_t;

  logic [KWIU_W-1:0] words_in_use;
  logic [13:0]       vertex_total;
  logic [12:0]       unique_total;
  logic [WORD_W-1:0] unique_keys [MAX_UNIQUE_DEF][KEY_WORDS_DEF];
  logic [11:0]       vertex_to_unique [MAX_VERTICES_DEF];
  dedup_result_t     pending_results [$];

  assign outstanding = pending_results.size();

  function automatic dedup_result_t resolve_item(input logic [1:0] f,
                                                 input logic [WORD_W-1:0] w0,
                                                 input logic [WORD_W-1:0] w1,
                                                 input logic [WORD_W-1:0] w2,
                                                 input logic [WORD_W-1:0] w3,
                                                 input logic [12:0] ov);
    dedup_result_t r;
    logic [WORD_W-1:0] key [KEY_WORDS_DEF];
    int n;
    bit same;
    r = '0;
    key[0] = w0;
    key[1] = w1;
    key[2] = w2;
    key[3] = w3;
    n = (words_in_use == 0) ? 1 : (words_in_use > KEY_WORDS_DEF) ? KEY_WORDS_DEF
                                                                     : words_in_use;
    case (f)
      FUNC_SUBMIT: begin
        if (vertex_total >= MAX_VERTICES_DEF) begin
          r.st = ST_FULL;
          return r;
        end
        for (int u = 0; u < unique_total; u++) begin
          same = 1;
          for (int w = 0; w < n; w++) if (unique_keys[u][w] != key[w]) same = 0;
          if (same) begin
            vertex_to_unique[vertex_total] = u[11:0];
            vertex_total++;
            r.idx = u[11:0];
            return r;
          end
        end
        if (unique_total >= MAX_UNIQUE_DEF) begin
          r.st = ST_FULL;
          return r;
        end
        for (int w = 0; w < KEY_WORDS_DEF; w++) unique_keys[unique_total][w] = key[w];
        vertex_to_unique[vertex_total] = unique_total[11:0];
        r.idx = unique_total[11:0];
        r.fresh = 1;
        r.pick = vertex_total[12:0];
        unique_total++;
        vertex_total++;
      end
      FUNC_XLATE: begin
        if (ov < vertex_total) r.idx = vertex_to_unique[ov];
        else r.st = ST_RANGE;
      end
      FUNC_CLEAR: begin
        vertex_total = 0;
        unique_total = 0;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    dedup_result_t want;
    if (rst) begin
      words_in_use = KWIU_RESET;
      vertex_total = 0;
      unique_total = 0;
      pending_results.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == APB_AW'(4 * REG_KWIU))
        words_in_use = pwdata[KWIU_W-1:0];
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result idx=%0d new=%0d pick=%0d st=%0d",
                   $time, new_index, is_new, pick_vertex, status);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (want.idx !== new_index) begin
            $display("%0t: new_index exp %0d got %0d", $time, want.idx, new_index);
            fail_count++;
          end
          if (want.fresh !== is_new) begin
            $display("%0t: is_new exp %0d got %0d", $time, want.fresh, is_new);
            fail_count++;
          end
          if (want.pick !== pick_vertex) begin
            $display("%0t: pick_vertex exp %0d got %0d", $time, want.pick, pick_vertex);
            fail_count++;
          end
          if (want.st !== status) begin
            $display("%0t: status exp %0d got %0d", $time, want.st, status);
            fail_count++;
          end
        end
      end
      if (push && !full)
        pending_results.insert(pending_results.size(),
                               resolve_item(func, key_word_0, key_word_1,
                                            key_word_2, key_word_3, old_vertex));
    end
  end

endmodule

// ===== dv/vertex_dedup_indexer_tb.sv =====
// ----------------------------------------------------------------------------
// vertex_dedup_indexer_tb
// Drives the vertex dedup indexer with directed and random items under
// several key word counts, with bursty input and a stalling receiver. A
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module vertex_dedup_indexer_tb import vdi_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  logic              clk = 0;
  logic              rst = 1;
  logic              psel = 0, penable = 0, pwrite = 0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              push = 0, full;
  logic [1:0]        func = FUNC_SUBMIT;
  logic [WORD_W-1:0] key_word_0 = '0, key_word_1 = '0, key_word_2 = '0, key_word_3 = '0;
  logic [12:0]       old_vertex = '0;
  logic              empty, pop = 0;
  logic [11:0]       new_index;
  logic              is_new;
  logic [12:0]       pick_vertex;
  logic [1:0]        status;
  int                fail_count, outstanding;

  int                burst_left = 1;
  int                cur_words = KWIU_RESET;
  int                submits_since_clear = 0;
  logic [WORD_W-1:0] key_pool [32][4];

  always #5 clk = ~clk;

  vertex_dedup_indexer i_dut (.*);

  vertex_dedup_indexer_checker i_checker (.*);

  int stall_phase = 0;
  always @(negedge clk) begin
    stall_phase++;
    case ((stall_phase / 300) % 3)
      0: pop <= 1;
      1: pop <= ($urandom_range(0, 1) == 1);
      default: pop <= ((stall_phase % 9) < 3);
    endcase
  end

  function automatic logic [WORD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_item(input logic [1:0] f, input logic [WORD_W-1:0] w0,
                           input logic [WORD_W-1:0] w1, input logic [WORD_W-1:0] w2,
                           input logic [WORD_W-1:0] w3, input logic [12:0] ov);
    int gap;
    func = f;
    key_word_0 = w0;
    key_word_1 = w1;
    key_word_2 = w2;
    key_word_3 = w3;
    old_vertex = ov;
    push = 1;
    while (full) @(negedge clk);
    @(negedge clk);
    if (f == FUNC_SUBMIT) submits_since_clear++;
    if (f == FUNC_CLEAR) submits_since_clear = 0;
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 30);
      if (gap > 0) begin
        push = 0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic drain_and_write(input int words);
    push = 0;
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    psel = 1;
    pwrite = 1;
    penable = 0;
    paddr = APB_AW'(4 * REG_KWIU);
    pwdata = APB_DW'(words);
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    psel = 0;
    penable = 0;
    pwrite = 0;
    cur_words = words;
  endtask

  task automatic random_item();
    int roll, p, n;
    logic [WORD_W-1:0] w [4];
    roll = $urandom_range(0, 99);
    p = $urandom_range(0, 31);
    for (int i = 0; i < 4; i++) w[i] = key_pool[p][i];
    n = (cur_words == 0) ? 1 : (cur_words > 4) ? 4 : cur_words;
    if (roll < 60) begin
      if (n < 4 && $urandom_range(0, 2) == 0) w[$urandom_range(n, 3)] = rand_word();
      send_item(FUNC_SUBMIT, w[0], w[1], w[2], w[3], 13'($urandom));
    end else if (roll < 70) begin
      send_item(FUNC_SUBMIT, rand_word(), rand_word(), rand_word(), rand_word(),
                13'($urandom));
    end else if (roll < 90) begin
      send_item(FUNC_XLATE, rand_word(), rand_word(), rand_word(), rand_word(),
                13'($urandom_range(0, submits_since_clear + 2)));
    end else if (roll < 93) begin
      send_item(FUNC_CLEAR, rand_word(), rand_word(), rand_word(), rand_word(),
                13'($urandom));
    end else if (roll < 96) begin
      send_item(OP_NOP, rand_word(), rand_word(), rand_word(), rand_word(),
                13'($urandom));
    end else begin
      send_item(FUNC_XLATE, '0, '0, '0, '0, 13'($urandom));
    end
  endtask

  initial begin
    int word_settings [7] = '{4, 1, 0, 7, 2, 3, 5};
    logic [WORD_W-1:0] ones;
    ones = '1;
    for (int i = 0; i < 32; i++)
      for (int j = 0; j < 4; j++) key_pool[i][j] = rand_word();
    repeat (12) @(negedge clk);
    rst = 0;
    @(negedge clk);

    send_item(FUNC_XLATE, '0, '0, '0, '0, 13'd0);
    send_item(FUNC_SUBMIT, '0, '0, '0, '0, '0);
    send_item(FUNC_SUBMIT, ones, ones, ones, ones, '1);
    send_item(FUNC_SUBMIT, '0, '0, '0, '0, '0);
    send_item(FUNC_SUBMIT, ones, ones, ones, '0, '0);
    send_item(FUNC_SUBMIT, ones, ones, ones, ones, '0);
    send_item(FUNC_XLATE, '0, '0, '0, '0, 13'd0);
    send_item(FUNC_XLATE, '0, '0, '0, '0, 13'd3);
    send_item(FUNC_XLATE, '0, '0, '0, '0, 13'd5);
    send_item(FUNC_XLATE, ones, ones, ones, ones, '1);
    send_item(OP_NOP, ones, ones, ones, ones, '1);
    send_item(FUNC_CLEAR, '0, '0, '0, '0, '0);
    send_item(FUNC_XLATE, '0, '0, '0, '0, 13'd0);
    send_item(FUNC_SUBMIT, ones, '0, ones, '0, '0);

    foreach (word_settings[s]) begin
      drain_and_write(word_settings[s]);
      for (int i = 0; i < 190; i++) random_item();
    end

    push = 0;
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) $display("vertex_dedup_indexer_tb: clean");
    else $display("vertex_dedup_indexer_tb: errors");
    $finish;
  end

  initial begin
    #200ms;
    $display("vertex_dedup_indexer_tb: errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/vdi_pkg.sv
rtl/core/vdi_front.sv
rtl/core/vdi_back.sv
rtl/core/vertex_dedup_indexer.sv
dv/vertex_dedup_indexer_checker.sv
dv/vertex_dedup_indexer_tb.sv
